@@ rtl/pctt_pkg.sv @@
// Package: shared widths, codes, payload structs and controller/datapath interface types.
package pctt_pkg;

	localparam int MAC_W           = 48;
	localparam int TIME_W          = 32;
	localparam int CNT_W           = 5;
	localparam int STS_W           = 3;
	localparam int APB_AW          = 4;
	localparam int APB_DW          = 64;
	localparam int TABLE_DEPTH_DEF = 16;

	localparam logic [MAC_W-1:0] MAC_BCAST = '1;
	localparam logic [MAC_W-1:0] MAC_ZERO  = '0;
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	typedef enum logic [1:0] {
		MODE_BEACON = 2'd0,
		MODE_OWN    = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_OWN_SRC   = 3'd2,
		ST_UNCHANGED = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic {
		REG_SELF_MAC   = 1'b0,
		REG_STABLE_WIN = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ADDR_I  = 2'd0,
		ADDR_J  = 2'd1,
		ADDR_LI = 2'd2
	} addr_sel_t;

	typedef enum logic [1:0] {
		START_SELF = 2'd0,
		START_RAM  = 2'd1,
		START_HOP  = 2'd2
	} start_sel_t;

	typedef enum logic [1:0] {
		PH_CHAIN = 2'd0,
		PH_HOP   = 2'd1,
		PH_LOOP  = 2'd2
	} phase_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_OWN, S_B_RD, S_B_CHK, S_B_WR, S_Q_INIT,
		S_R_RDI, S_R_LDI, S_R_SCAN, S_R_CMP, S_R_NEXT, S_R_END,
		S_H_RD, S_H_CHK, S_L_SCAN, S_L_LD, S_Q_FIN, S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [MAC_W-1:0]  source_mac;
		logic [MAC_W-1:0]  in_peer_mac;
		logic [MAC_W-1:0]  out_peer_mac;
		logic [MAC_W-1:0]  first_hop_mac;
		logic [TIME_W-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic             graph_changed;
		logic [CNT_W-1:0] chain_members;
		logic [CNT_W-1:0] reachable_via_hop;
		logic             in_loop;
		logic             topology_stable;
	} rsp_t;

	typedef struct packed {
		logic [MAC_W-1:0] src;
		logic [MAC_W-1:0] in_p;
		logic [MAC_W-1:0] out_p;
	} entry_t;

	typedef struct packed {
		logic       ld_item;
		logic       res_clr;
		logic       own_upd;
		logic       i_clr;
		logic       i_inc;
		logic       j_clr;
		logic       j_inc;
		logic       li_clr;
		logic       li_inc;
		addr_sel_t  addr_sel;
		logic       ld_ei;
		logic       free_rec;
		logic       tgt_hit;
		logic       tgt_free;
		logic       tbl_wr;
		logic       ld_start;
		start_sel_t start_sel;
		logic       block_self;
		logic       reach_clr;
		logic       pass_clr;
		logic       mark_i;
		logic       nb_set;
		logic       nb_clr;
		logic       loop_chk;
		logic       set_status;
		status_t    status;
		logic       set_chain;
		logic       set_hop;
		logic       set_fin;
		logic       push;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  src_bad;
		logic  src_self;
		logic  i_last;
		logic  j_last;
		logic  li_last;
		logic  hit_src;
		logic  peers_same;
		logic  free_any;
		logic  i_skip;
		logic  seed_hit;
		logic  mark_j;
		logic  mutual_hit;
		logic  pass_chg;
		logic  hop_ok;
		logic  hop_hit;
		logic  nb_li;
		logic  loop_flag;
	} sts_t;

endpackage

@@ rtl/peer_chain_topology_tracker.sv @@
// Top level: APB registers, controller, datapath and the result output register.
// A beacon scans the table for its source or a free slot, then writes a changed or new entry.
// Query: each reach sweeps the table until a sweep marks nothing (at most TABLE_DEPTH+1 sweeps),
//   per entry, the sweep scans the slots for marks and compares each marked slot with the entry;
//   reaches: chain, valid first hop (looked up first), each mutual neighbor of self till a loop.
// One item at a time, next accepted while a result waits; reset clears valid bits, own peers,
//   change time and registers, table contents stay undefined.
module peer_chain_topology_tracker import pctt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp
);

	logic [MAC_W-1:0]  self_mac_q;
	logic [TIME_W-1:0] win_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	cmd_t              cmd;
	sts_t              sts;
	rsp_t              result;
	logic              out_free;
	reg_idx_t          reg_idx;

	// configuration registers, 8-byte spacing
	assign reg_idx = reg_idx_t'(paddr[3]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_mac_q <= '0;
			win_q      <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_SELF_MAC:   self_mac_q <= pwdata[MAC_W-1:0];
				REG_STABLE_WIN: win_q      <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SELF_MAC:   prdata = {{(APB_DW-MAC_W){1'b0}}, self_mac_q};
			REG_STABLE_WIN: prdata = {{(APB_DW-TIME_W){1'b0}}, win_q};
			default:        prdata = '0;
		endcase
	end

	// output register decouples the result side from the sequencer
	assign out_free = !rsp_valid_q || rsp_ready;

	pctt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.out_free  (out_free),
		.sts       (sts),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	pctt_dp #(.DEPTH(TABLE_DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.self_mac      (self_mac_q),
		.stable_window (win_q),
		.cmd           (cmd),
		.sts           (sts),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) rsp_q <= result;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	// a finished result never overwrites one still waiting
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!rsp_valid_q || rsp_ready))
		else $error("result pushed into full output register");

	// one item in flight: no transfer right after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("input accepted while an item is in flight");

	// query results carry counts and always report status ok
	a_query_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.chain_members != '0)) |-> (rsp_q.status == ST_OK))
		else $error("query result with nonzero status");
`endif

endmodule

@@ rtl/pctt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pctt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/pctt_dp.sv @@
// Datapath: beacon table, own peers, sweep counters, reach marks and result fields.
module pctt_dp import pctt_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  req_t              req,
	input  logic [MAC_W-1:0]  self_mac,
	input  logic [TIME_W-1:0] stable_window,
	input  cmd_t              cmd,
	output sts_t              sts,
	output rsp_t              result
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	req_t              item_q;
	logic [MAC_W-1:0]  own_in_q, own_out_q;
	logic [TIME_W-1:0] last_q;
	logic              chg_rec_q;
	logic [DEPTH-1:0]  valid_q, mark_q, nb_q;
	logic [IW-1:0]     i_q, j_q, li_q, free_q, tgt_q;
	logic              free_ok_q, pass_q, loop_q;
	logic [CNT_W-1:0]  cnt_q;
	entry_t            ei_q;
	logic [MAC_W-1:0]  st_mac_q, st_in_q, st_out_q;
	logic              st_has_q, block_q;
	rsp_t              res_q;

	logic [IW-1:0]     raddr;
	logic [$bits(entry_t)-1:0] rd_raw;
	entry_t            rdata, wr_entry;
	logic              cur_valid, own_diff;
	logic [TIME_W-1:0] gap;

	always_comb begin
		unique case (cmd.addr_sel)
			ADDR_I:  raddr = i_q;
			ADDR_J:  raddr = j_q;
			ADDR_LI: raddr = li_q;
			default: raddr = i_q;
		endcase
	end

	assign wr_entry = '{src: item_q.source_mac, in_p: item_q.in_peer_mac,
		out_p: item_q.out_peer_mac};

	pctt_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (cmd.tbl_wr),
		.waddr (tgt_q),
		.wdata (wr_entry),
		.raddr (raddr),
		.rdata (rd_raw)
	);

	assign rdata     = entry_t'(rd_raw);
	assign cur_valid = valid_q[i_q];
	assign own_diff  = (own_in_q != item_q.in_peer_mac) || (own_out_q != item_q.out_peer_mac);
	assign gap       = (item_q.now_ms >= last_q) ? item_q.now_ms - last_q : '0;

	always_comb begin
		sts.mode       = mode_t'(item_q.mode);
		sts.src_bad    = (item_q.source_mac == MAC_ZERO) || (item_q.source_mac == MAC_BCAST);
		sts.src_self   = item_q.source_mac == self_mac;
		sts.i_last     = i_q == LAST;
		sts.j_last     = j_q == LAST;
		sts.li_last    = li_q == LAST;
		sts.hit_src    = cur_valid && (rdata.src == item_q.source_mac);
		sts.peers_same = (rdata.in_p == item_q.in_peer_mac) &&
			(rdata.out_p == item_q.out_peer_mac);
		sts.free_any   = free_ok_q || !cur_valid;
		sts.i_skip     = !cur_valid || mark_q[i_q] || (rdata.src == st_mac_q) ||
			(block_q && (rdata.src == self_mac));
		sts.seed_hit   = st_has_q &&
			((st_in_q == rdata.src) || (st_out_q == rdata.src)) &&
			((rdata.in_p == st_mac_q) || (rdata.out_p == st_mac_q));
		sts.mark_j     = mark_q[j_q];
		// rdata holds entry j here, ei_q entry i
		sts.mutual_hit = ((rdata.in_p == ei_q.src) || (rdata.out_p == ei_q.src)) &&
			((ei_q.in_p == rdata.src) || (ei_q.out_p == rdata.src));
		sts.pass_chg   = pass_q;
		sts.hop_ok     = (item_q.first_hop_mac != MAC_ZERO) &&
			(item_q.first_hop_mac != self_mac) &&
			((own_in_q == item_q.first_hop_mac) || (own_out_q == item_q.first_hop_mac));
		sts.hop_hit    = cur_valid && (rdata.src == item_q.first_hop_mac);
		sts.nb_li      = nb_q[li_q];
		sts.loop_flag  = loop_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_in_q  <= '0;
			own_out_q <= '0;
			last_q    <= '0;
			chg_rec_q <= 1'b0;
			valid_q   <= '0;
			mark_q    <= '0;
			nb_q      <= '0;
			i_q       <= '0;
			j_q       <= '0;
			li_q      <= '0;
			free_ok_q <= 1'b0;
			pass_q    <= 1'b0;
			loop_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cmd.i_clr) i_q <= '0;
			else if (cmd.i_inc) i_q <= i_q + IW'(1);
			if (cmd.j_clr) j_q <= '0;
			else if (cmd.j_inc) j_q <= j_q + IW'(1);
			if (cmd.li_clr) li_q <= '0;
			else if (cmd.li_inc) li_q <= li_q + IW'(1);

			if (cmd.ld_item) free_ok_q <= 1'b0;
			else if (cmd.free_rec && !cur_valid && !free_ok_q) free_ok_q <= 1'b1;

			if (cmd.tbl_wr) begin
				valid_q[tgt_q] <= 1'b1;
				last_q         <= item_q.now_ms;
				chg_rec_q      <= 1'b1;
			end
			if (cmd.own_upd && own_diff) begin
				own_in_q  <= item_q.in_peer_mac;
				own_out_q <= item_q.out_peer_mac;
				last_q    <= item_q.now_ms;
				chg_rec_q <= 1'b1;
			end

			if (cmd.nb_clr) nb_q <= '0;
			else if (cmd.nb_set) nb_q[i_q] <= 1'b1;

			if (cmd.res_clr) loop_q <= 1'b0;
			else if (cmd.mark_i && cmd.loop_chk && nb_q[i_q] && (i_q > li_q)) loop_q <= 1'b1;

			if (cmd.reach_clr) begin
				mark_q <= '0;
				cnt_q  <= CNT_W'(1);
				pass_q <= 1'b0;
			end else if (cmd.mark_i) begin
				mark_q[i_q] <= 1'b1;
				cnt_q       <= (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);
				pass_q      <= 1'b1;
			end else if (cmd.pass_clr) begin
				pass_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.ld_item) item_q <= req;
		if (cmd.free_rec && !cur_valid && !free_ok_q) free_q <= i_q;
		if (cmd.tgt_hit) tgt_q <= i_q;
		else if (cmd.tgt_free) tgt_q <= free_ok_q ? free_q : i_q;
		if (cmd.ld_ei) ei_q <= rdata;
		if (cmd.ld_start) begin
			block_q <= cmd.block_self;
			unique case (cmd.start_sel)
				START_SELF: begin
					st_mac_q <= self_mac;
					st_in_q  <= own_in_q;
					st_out_q <= own_out_q;
					st_has_q <= 1'b1;
				end
				START_RAM: begin
					st_mac_q <= rdata.src;
					st_in_q  <= rdata.in_p;
					st_out_q <= rdata.out_p;
					st_has_q <= 1'b1;
				end
				default: begin
					st_mac_q <= item_q.first_hop_mac;
					st_in_q  <= MAC_ZERO;
					st_out_q <= MAC_ZERO;
					st_has_q <= 1'b0;
				end
			endcase
		end
		if (cmd.res_clr) begin
			res_q <= '0;
		end else begin
			if (cmd.set_status) res_q.status <= cmd.status;
			if (cmd.tbl_wr || (cmd.own_upd && own_diff)) res_q.graph_changed <= 1'b1;
			if (cmd.set_chain) res_q.chain_members <= cnt_q;
			if (cmd.set_hop) res_q.reachable_via_hop <= cnt_q;
			if (cmd.set_fin) begin
				res_q.in_loop         <= loop_q;
				res_q.topology_stable <= chg_rec_q && (gap >= stable_window);
			end
		end
	end

	assign result = res_q;

endmodule

@@ rtl/pctt_ctrl.sv @@
// Controller: sequences beacon lookup/store, own-peer update and the query sweeps.
module pctt_ctrl import pctt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic out_free,
	input  sts_t sts,
	output logic req_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_CHAIN;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_d = S_DISP;
			S_DISP: begin
				unique case (sts.mode)
					MODE_BEACON: state_d = (sts.src_bad || sts.src_self) ? S_DONE : S_B_RD;
					MODE_OWN:    state_d = S_OWN;
					MODE_QUERY:  state_d = S_Q_INIT;
					default:     state_d = S_DONE;
				endcase
			end
			S_OWN:  state_d = S_DONE;
			S_B_RD: state_d = S_B_CHK;
			S_B_CHK: begin
				if (sts.hit_src) state_d = sts.peers_same ? S_DONE : S_B_WR;
				else if (sts.i_last) state_d = sts.free_any ? S_B_WR : S_DONE;
				else state_d = S_B_RD;
			end
			S_B_WR: state_d = S_DONE;
			S_Q_INIT: begin
				phase_d = PH_CHAIN;
				state_d = S_R_RDI;
			end
			S_R_RDI: state_d = S_R_LDI;
			S_R_LDI: state_d = (sts.i_skip || sts.seed_hit) ? S_R_NEXT : S_R_SCAN;
			S_R_SCAN: begin
				if (sts.mark_j) state_d = S_R_CMP;
				else if (sts.j_last) state_d = S_R_NEXT;
			end
			S_R_CMP: begin
				if (sts.mutual_hit || sts.j_last) state_d = S_R_NEXT;
				else state_d = S_R_SCAN;
			end
			S_R_NEXT: begin
				if (sts.i_last && !sts.pass_chg) state_d = S_R_END;
				else state_d = S_R_RDI;
			end
			S_R_END: begin
				unique case (phase_q)
					PH_CHAIN: state_d = sts.hop_ok ? S_H_RD : S_L_SCAN;
					PH_HOP:   state_d = S_L_SCAN;
					default:  state_d = (sts.loop_flag || sts.li_last) ? S_Q_FIN : S_L_SCAN;
				endcase
			end
			S_H_RD: state_d = S_H_CHK;
			S_H_CHK: begin
				if (sts.hop_hit || sts.i_last) begin
					phase_d = PH_HOP;
					state_d = S_R_RDI;
				end else begin
					state_d = S_H_RD;
				end
			end
			S_L_SCAN: begin
				if (sts.nb_li) state_d = S_L_LD;
				else if (sts.li_last) state_d = S_Q_FIN;
			end
			S_L_LD: begin
				phase_d = PH_LOOP;
				state_d = S_R_RDI;
			end
			S_Q_FIN: state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		cmd.addr_sel = ADDR_I;
		cmd.status   = ST_OK;
		req_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.ld_item = req_valid;
				cmd.res_clr = req_valid;
				cmd.i_clr   = req_valid;
				cmd.nb_clr  = req_valid;
			end
			S_DISP: begin
				if (sts.mode == MODE_BEACON && sts.src_bad) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_INVALID;
				end else if (sts.mode == MODE_BEACON && sts.src_self) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_OWN_SRC;
				end
			end
			S_OWN: cmd.own_upd = 1'b1;
			S_B_CHK: begin
				if (sts.hit_src) begin
					if (sts.peers_same) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_UNCHANGED;
					end else begin
						cmd.tgt_hit = 1'b1;
					end
				end else begin
					cmd.free_rec = 1'b1;
					if (!sts.i_last) begin
						cmd.i_inc = 1'b1;
					end else if (sts.free_any) begin
						cmd.tgt_free = 1'b1;
					end else begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_FULL;
					end
				end
			end
			S_B_WR: cmd.tbl_wr = 1'b1;
			S_Q_INIT: begin
				cmd.ld_start  = 1'b1;
				cmd.start_sel = START_SELF;
				cmd.reach_clr = 1'b1;
				cmd.i_clr     = 1'b1;
			end
			S_R_LDI: begin
				cmd.ld_ei = 1'b1;
				if (!sts.i_skip && sts.seed_hit) begin
					cmd.mark_i   = 1'b1;
					cmd.nb_set   = phase_q == PH_CHAIN;
					cmd.loop_chk = phase_q == PH_LOOP;
				end else if (!sts.i_skip) begin
					cmd.j_clr = 1'b1;
				end
			end
			S_R_SCAN: begin
				if (sts.mark_j) cmd.addr_sel = ADDR_J;
				else if (!sts.j_last) cmd.j_inc = 1'b1;
			end
			S_R_CMP: begin
				if (sts.mutual_hit) begin
					cmd.mark_i   = 1'b1;
					cmd.loop_chk = phase_q == PH_LOOP;
				end else if (!sts.j_last) begin
					cmd.j_inc = 1'b1;
				end
			end
			S_R_NEXT: begin
				if (!sts.i_last) begin
					cmd.i_inc = 1'b1;
				end else if (sts.pass_chg) begin
					cmd.i_clr    = 1'b1;
					cmd.pass_clr = 1'b1;
				end
			end
			S_R_END: begin
				unique case (phase_q)
					PH_CHAIN: begin
						cmd.set_chain = 1'b1;
						cmd.i_clr     = 1'b1;
						cmd.li_clr    = 1'b1;
					end
					PH_HOP: begin
						cmd.set_hop = 1'b1;
						cmd.li_clr  = 1'b1;
					end
					default: cmd.li_inc = !(sts.loop_flag || sts.li_last);
				endcase
			end
			S_H_CHK: begin
				if (sts.hop_hit || sts.i_last) begin
					cmd.ld_start   = 1'b1;
					cmd.start_sel  = sts.hop_hit ? START_RAM : START_HOP;
					cmd.block_self = 1'b1;
					cmd.reach_clr  = 1'b1;
					cmd.i_clr      = 1'b1;
				end else begin
					cmd.i_inc = 1'b1;
				end
			end
			S_L_SCAN: begin
				if (sts.nb_li) cmd.addr_sel = ADDR_LI;
				else if (!sts.li_last) cmd.li_inc = 1'b1;
			end
			S_L_LD: begin
				cmd.ld_start   = 1'b1;
				cmd.start_sel  = START_RAM;
				cmd.block_self = 1'b1;
				cmd.reach_clr  = 1'b1;
				cmd.i_clr      = 1'b1;
			end
			S_Q_FIN: cmd.set_fin = 1'b1;
			S_DONE:  cmd.push = out_free;
			default: ;
		endcase
	end

endmodule

@@ verif/pctt_checker.sv @@
// Result checker: mirrors the tracker's table and compares every response transfer.
module pctt_checker import pctt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_ready,
	input  req_t       req,
	input  logic       rsp_valid,
	input  logic       rsp_ready,
	input  rsp_t       rsp,
	input  logic [47:0] self_mac,
	input  logic [31:0] stable_window,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = TABLE_DEPTH_DEF;

	logic [MAC_W-1:0] tbl_src [DEPTH];
	logic [MAC_W-1:0] tbl_in [DEPTH];
	logic [MAC_W-1:0] tbl_out [DEPTH];
	logic             tbl_vld [DEPTH];
	logic [MAC_W-1:0] own_in, own_out;
	logic [31:0]      change_time;
	logic             change_seen;
	rsp_t             expected_rsp [$];
	int               mismatches;

	function automatic int lookup(logic [MAC_W-1:0] mac);
		for (int i = 0; i < DEPTH; i++)
			if (tbl_vld[i] && tbl_src[i] == mac) return i;
		return -1;
	endfunction

	function automatic bit claims(logic [MAC_W-1:0] a, logic [MAC_W-1:0] b);
		int k;
		if (a == self_mac) return own_in == b || own_out == b;
		k = lookup(a);
		if (k < 0) return 0;
		return tbl_in[k] == b || tbl_out[k] == b;
	endfunction

	function automatic bit linked(logic [MAC_W-1:0] a, logic [MAC_W-1:0] b);
		return claims(a, b) && claims(b, a);
	endfunction

	// flood fill over mutual edges; count includes the start node
	function automatic int flood(logic [MAC_W-1:0] start, bit no_self, ref bit mark [DEPTH]);
		int  cnt;
		bit  grew, hit;
		for (int i = 0; i < DEPTH; i++) mark[i] = 0;
		if (no_self && start == self_mac) return 0;
		cnt = 1;
		grew = 1;
		while (grew) begin
			grew = 0;
			for (int i = 0; i < DEPTH; i++) begin
				if (!tbl_vld[i] || mark[i] || tbl_src[i] == start) continue;
				if (no_self && tbl_src[i] == self_mac) continue;
				hit = linked(start, tbl_src[i]);
				for (int j = 0; j < DEPTH && !hit; j++)
					if (mark[j] && linked(tbl_src[j], tbl_src[i])) hit = 1;
				if (hit) begin
					mark[i] = 1;
					cnt++;
					grew = 1;
				end
			end
		end
		return cnt;
	endfunction

	function automatic logic [CNT_W-1:0] clamp5(int v);
		return v > 31 ? 5'd31 : v[CNT_W-1:0];
	endfunction

	function automatic bit self_in_loop();
		bit nb [DEPTH];
		bit mark [DEPTH];
		int n;
		n = 0;
		for (int i = 0; i < DEPTH; i++) begin
			nb[i] = tbl_vld[i] && linked(self_mac, tbl_src[i]);
			if (nb[i]) n++;
		end
		if (n < 2) return 0;
		for (int i = 0; i < DEPTH; i++) begin
			if (!nb[i]) continue;
			void'(flood(tbl_src[i], 1, mark));
			for (int j = i + 1; j < DEPTH; j++)
				if (nb[j] && mark[j]) return 1;
		end
		return 0;
	endfunction

	function automatic rsp_t track(req_t r);
		rsp_t o;
		int   k;
		bit   mark [DEPTH];
		logic [31:0] gap;
		o = '0;
		case (mode_t'(r.mode))
			MODE_BEACON: begin
				if (r.source_mac == MAC_ZERO || r.source_mac == MAC_BCAST) begin
					o.status = ST_INVALID;
					return o;
				end
				if (r.source_mac == self_mac) begin
					o.status = ST_OWN_SRC;
					return o;
				end
				k = lookup(r.source_mac);
				if (k >= 0) begin
					if (tbl_in[k] == r.in_peer_mac && tbl_out[k] == r.out_peer_mac) begin
						o.status = ST_UNCHANGED;
						return o;
					end
				end else begin
					for (int i = 0; i < DEPTH && k < 0; i++)
						if (!tbl_vld[i]) k = i;
					if (k < 0) begin
						o.status = ST_FULL;
						return o;
					end
				end
				tbl_vld[k] = 1;
				tbl_src[k] = r.source_mac;
				tbl_in[k] = r.in_peer_mac;
				tbl_out[k] = r.out_peer_mac;
				change_time = r.now_ms;
				change_seen = 1;
				o.graph_changed = 1;
			end
			MODE_OWN: begin
				if (own_in != r.in_peer_mac || own_out != r.out_peer_mac) begin
					own_in = r.in_peer_mac;
					own_out = r.out_peer_mac;
					change_time = r.now_ms;
					change_seen = 1;
					o.graph_changed = 1;
				end
			end
			MODE_QUERY: begin
				o.chain_members = clamp5(flood(self_mac, 0, mark));
				if (r.first_hop_mac != 0 && r.first_hop_mac != self_mac &&
						(own_in == r.first_hop_mac || own_out == r.first_hop_mac))
					o.reachable_via_hop = clamp5(flood(r.first_hop_mac, 1, mark));
				o.in_loop = self_in_loop();
				if (change_seen) begin
					gap = r.now_ms >= change_time ? r.now_ms - change_time : 32'd0;
					o.topology_stable = gap >= stable_window;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	assign pending = expected_rsp.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) tbl_vld[i] = 0;
			own_in = '0;
			own_out = '0;
			change_time = '0;
			change_seen = 0;
			fail_count = 0;
			mismatches = 0;
			expected_rsp.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					fail_count++;
					if (mismatches++ < 10) $display("unexpected result transfer %h", rsp);
				end else begin
					e = expected_rsp.pop_front();
					if (e !== rsp) begin
						fail_count++;
						if (mismatches++ < 10)
							$display("mismatch: sts %0d/%0d chg %0d/%0d chain %0d/%0d hop %0d/%0d loop %0d/%0d stable %0d/%0d",
								e.status, rsp.status, e.graph_changed, rsp.graph_changed,
								e.chain_members, rsp.chain_members,
								e.reachable_via_hop, rsp.reachable_via_hop,
								e.in_loop, rsp.in_loop, e.topology_stable, rsp.topology_stable);
					end
				end
			end
			if (req_valid && req_ready) expected_rsp.insert(expected_rsp.size(), track(req));
		end
	end

endmodule

@@ verif/testbench.sv @@
// Testbench top: drives beacons, own-peer updates and queries, and reports the verdict.
module testbench;
	import pctt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              psel = 0, penable = 0, pwrite = 0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              req_valid = 0;
	logic              req_ready;
	req_t              req = '0;
	logic              rsp_valid;
	logic              rsp_ready = 0;
	rsp_t              rsp;

	// shadow of the registers, fed to the checker
	logic [47:0] self_mac = '0;
	logic [31:0] stable_window = '0;
	int          fail_count, pending;
	int          cycles = 0;
	int          sent = 0;
	bit          hold_rsp = 0;  // long receiver hold-off

	// small MAC pool so beacons collide, link up and fill the table
	logic [47:0] pool [24];
	logic [31:0] clock_ms = 0;

	always #5 clk = ~clk;

	peer_chain_topology_tracker uut (.*);

	pctt_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 40_000_000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stalls, some long; a long hold-off when requested
	always @(posedge clk) begin
		if (hold_rsp) rsp_ready <= 0;
		else if ($urandom_range(0, 9) < 7) rsp_ready <= 1;
		else rsp_ready <= ($urandom_range(0, 19) == 0) ? 1 : 0;
	end

	task automatic reg_write(reg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= APB_AW'(8 * idx); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_SELF_MAC) self_mac = val[47:0];
		else stable_window = val[31:0];
	endtask

	// one transfer; wait a random gap first, then hold valid until accepted
	task automatic send(req_t r);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		repeat (gap) @(posedge clk);
		req_valid <= 1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		req_valid <= 0;
		sent++;
	endtask

	function automatic logic [47:0] rand_mac();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [47:0] pick();
		int c;
		c = $urandom_range(0, 19);
		if (c == 0) return MAC_ZERO;
		if (c == 1) return self_mac;
		if (c == 2) return rand_mac();
		return pool[$urandom_range(0, 23)];
	endfunction

	function automatic req_t mk(mode_t m, logic [47:0] s, logic [47:0] i,
			logic [47:0] o, logic [47:0] h);
		req_t r;
		r.mode = m;
		r.source_mac = s;
		r.in_peer_mac = i;
		r.out_peer_mac = o;
		r.first_hop_mac = h;
		// mostly advancing clock, occasionally backwards
		if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
		else clock_ms = clock_ms + $urandom_range(0, 300);
		r.now_ms = clock_ms;
		return r;
	endfunction

	// let the last accepted transfer be counted first, then wait until nothing is pending
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// chain self - pool[0] - pool[1] - ... and optional closure back to self
	task automatic build_chain(int len, bit close);
		for (int k = 0; k < len; k++)
			send(mk(MODE_BEACON, pool[k], k == 0 ? self_mac : pool[k-1],
				(k == len - 1) ? (close ? self_mac : MAC_ZERO) : pool[k+1], MAC_ZERO));
		send(mk(MODE_OWN, MAC_ZERO, pool[0], close ? pool[len-1] : MAC_ZERO, MAC_ZERO));
	endtask

	initial begin
		req_t r;
		for (int k = 0; k < 24; k++) pool[k] = 48'h02_00_00_00_10_00 + 48'(k * 48'h1_0101);
		pool[23] = 48'hFFFF_FFFF_FFFE;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// phase 1: default registers (self zero, window zero)
		send(mk(MODE_QUERY, MAC_ZERO, MAC_ZERO, MAC_ZERO, MAC_ZERO));
		send(mk(MODE_BEACON, MAC_ZERO, 48'd1, 48'd2, MAC_ZERO));
		send(mk(MODE_BEACON, MAC_BCAST, 48'd1, 48'd2, MAC_ZERO));
		send(mk(MODE_OWN, MAC_ZERO, MAC_ZERO, MAC_ZERO, MAC_ZERO));
		send(mk(MODE_RSVD, pool[1], pool[2], pool[3], pool[4]));
		drain();

		reg_write(REG_SELF_MAC, 64'h0000_0A0B_0C0D_0E0F);
		reg_write(REG_STABLE_WIN, 64'd100);
		send(mk(MODE_BEACON, self_mac, 48'd1, 48'd2, MAC_ZERO));
		build_chain(4, 1);
		send(mk(MODE_BEACON, pool[0], self_mac, pool[1], MAC_ZERO));  // unchanged duplicate
		send(mk(MODE_BEACON, pool[2], pool[1], pool[5], MAC_ZERO));   // overwrite in place
		send(mk(MODE_OWN, MAC_ZERO, pool[0], pool[3], MAC_ZERO));     // own peers unchanged
		send(mk(MODE_QUERY, MAC_ZERO, MAC_ZERO, MAC_ZERO, pool[0]));
		send(mk(MODE_QUERY, MAC_ZERO, MAC_ZERO, MAC_ZERO, self_mac));
		send(mk(MODE_QUERY, MAC_ZERO, MAC_ZERO, MAC_ZERO, pool[9]));
		r = mk(MODE_QUERY, MAC_ZERO, MAC_ZERO, MAC_ZERO, pool[3]);
		r.now_ms = 32'd0;                                             // backwards clock
		send(r);
		// fill table to full, then two more new sources
		for (int k = 4; k < 18; k++)
			send(mk(MODE_BEACON, pool[k], pool[k+1], MAC_ZERO, MAC_ZERO));
		send(mk(MODE_QUERY, MAC_ZERO, MAC_ZERO, MAC_ZERO, pool[3]));

		// long receiver hold-off while the sender keeps offering
		hold_rsp = 1;
		fork
			begin
				repeat (3) send(mk(MODE_OWN, MAC_ZERO, pick(), pick(), MAC_ZERO));
			end
			begin
				repeat (3000) @(posedge clk);
				hold_rsp = 0;
			end
		join
		drain();

		// change self after beacons stored, extreme window
		reg_write(REG_SELF_MAC, {16'h0, pool[2]});
		reg_write(REG_STABLE_WIN, 64'hFFFF_FFFF);
		send(mk(MODE_QUERY, MAC_ZERO, MAC_ZERO, MAC_ZERO, pool[1]));
		drain();
		reg_write(REG_SELF_MAC, 64'h0000_FFFF_FFFF_FFFF);
		reg_write(REG_STABLE_WIN, 64'd0);
		send(mk(MODE_QUERY, MAC_ZERO, MAC_ZERO, MAC_ZERO, MAC_ZERO));
		send(mk(MODE_BEACON, rand_mac(), rand_mac(), rand_mac(), MAC_ZERO));
		r = mk(MODE_QUERY, MAC_ZERO, MAC_ZERO, MAC_ZERO, rand_mac());
		r.now_ms = 32'hFFFF_FFFF;
		send(r);
		drain();

		// random part: a few register settings, well-formed chains plus noise
		for (int ph = 0; ph < 3; ph++) begin
			reg_write(REG_SELF_MAC, {16'h0, 48'h0A_00_00_00_00_00 + 48'(ph)});
			reg_write(REG_STABLE_WIN, 64'($urandom_range(0, 500)));
			for (int n = 0; n < 33; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						int k;
						k = $urandom_range(0, 22);
						send(mk(MODE_BEACON, pick(), k == 0 ? self_mac : pool[k-1],
							$urandom_range(0, 3) == 0 ? pick() : pool[k+1], MAC_ZERO));
					end
					4:       send(mk(MODE_OWN, MAC_ZERO, pick(), pick(), MAC_ZERO));
					5:       send(mk(MODE_OWN, MAC_ZERO, pool[0],
						pool[$urandom_range(0, 22)], MAC_ZERO));
					6, 7, 8: send(mk(MODE_QUERY, pick(), pick(), pick(),
						$urandom_range(0, 1) ? pool[0] : pick()));
					default: send(mk(mode_t'($urandom_range(0, 3)),
						rand_mac(), rand_mac(), rand_mac(), rand_mac()));
				endcase
			end
			drain();
		end

		drain();
		$display("Covered %0d transfers: invalid/own/duplicate/full beacons, own-peer", sent);
		$display("updates, chain and loop queries, backwards clock, register extremes.");
		if (fail_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
